FILE: src/ssd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_pkg - shared types and constants of the seven-segment counter display
// Command codes, widths, the refresh job passed from front to back, the
// powers-of-ten table used for digit extraction and the segment encoder.
// ----------------------------------------------------------------------------
package ssd_pkg;

  // Display geometry
  localparam int DIGITS       = 4;
  localparam int VALUE_DIGITS = 4;   // decimal digits a stored value can span
  localparam int SCAN_DIGITS  = (DIGITS > VALUE_DIGITS) ? DIGITS : VALUE_DIGITS;
  localparam int POS_W        = $clog2(SCAN_DIGITS);

  // Field widths
  localparam int CMD_W    = 2;
  localparam int SAMPLE_W = 10;
  localparam int VAL_W    = 14;
  localparam int SEG_W    = 7;
  localparam int IDX_W    = 2;
  localparam int DIG_W    = 4;
  localparam int POW_W    = 28;      // holds nine times the largest power used

  localparam logic [VAL_W-1:0] COUNT_MAX = 14'd9999;
  localparam logic [POS_W:0]   DIGITS_P  = (POS_W+1)'(DIGITS);
  localparam logic [POS_W-1:0] TOP_POS   = POS_W'(SCAN_DIGITS - 1);

  // Refresh queue geometry
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_SAMPLE  = 2'd1,
    CMD_BUTTON  = 2'd2,
    CMD_REFRESH = 2'd3
  } cmd_t;

  // Snapshot of one refresh: value to show and the mode it is shown in
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             show_counter;
  } job_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef logic [POW_W-1:0] pow_tab_t [SCAN_DIGITS];

  function automatic pow_tab_t make_pow10();
    pow_tab_t         t;
    logic [POW_W-1:0] p;
    p = POW_W'(1);
    for (int i = 0; i < SCAN_DIGITS; i++) begin
      t[i] = p;
      p    = POW_W'(p * 10);
    end
    return t;
  endfunction

  localparam pow_tab_t POW10 = make_pow10();

  // Segment pattern gfedcba for one decimal digit
  function automatic logic [SEG_W-1:0] seg_of(input logic [DIG_W-1:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: src/ssd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_front - command front end
// Accepts items, keeps the counter, the converter sample and the display
// mode, and queues a snapshot of the shown value for every refresh.
// ----------------------------------------------------------------------------
module ssd_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             in_command,
  input  wire logic [9:0]             in_adc_sample,
  input  wire logic                   in_button_level,
  input  wire ssd_pkg::q_stat_t       q_stat,
  output logic                        q_push,
  output ssd_pkg::job_t               q_job
);
  import ssd_pkg::*;

  logic [VAL_W-1:0]    count_r, count_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic                show_counter_r, show_counter_nxt;
  logic                last_button_r, last_button_nxt;
  logic                accept;
  cmd_t                cmd;

  // Hold input while the refresh queue is full
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign cmd      = cmd_t'(in_command);

  // Decode the command and update state
  always_comb begin
    count_nxt        = count_r;
    sample_nxt       = sample_r;
    show_counter_nxt = show_counter_r;
    last_button_nxt  = last_button_r;
    q_push           = 1'b0;
    if (accept) begin
      unique case (cmd)
        CMD_TICK: begin
          count_nxt = (count_r >= COUNT_MAX) ? '0 : count_r + VAL_W'(1);
        end
        CMD_SAMPLE: begin
          sample_nxt = in_adc_sample;
        end
        CMD_BUTTON: begin
          if (last_button_r && !in_button_level) begin
            show_counter_nxt = !show_counter_r;
          end
          last_button_nxt = in_button_level;
        end
        CMD_REFRESH: begin
          q_push = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Snapshot of the value currently on show
  assign q_job.value        = show_counter_r ? count_r : VAL_W'(sample_r);
  assign q_job.show_counter = show_counter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r        <= '0;
      sample_r       <= '0;
      show_counter_r <= 1'b1;
      last_button_r  <= 1'b1;
    end else begin
      count_r        <= count_nxt;
      sample_r       <= sample_nxt;
      show_counter_r <= show_counter_nxt;
      last_button_r  <= last_button_nxt;
    end
  end

  // Counter never leaves its decimal range
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_MAX)
    else $error("counter beyond its wrap point");

endmodule
`default_nettype wire

FILE: src/ssd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_queue - refresh job queue
// Short first-in first-out buffer that decouples command decoding from digit
// emission.
// ----------------------------------------------------------------------------
module ssd_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire ssd_pkg::job_t    push_job,
  input  wire logic             pop,
  output ssd_pkg::job_t         pop_job,
  output ssd_pkg::q_stat_t      stat
);
  import ssd_pkg::*;

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_job    = slot_r[rd_ptr_r];

  // Write the pushed job
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      priority if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end else begin
        cnt_r <= cnt_r;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from an empty queue");

endmodule
`default_nettype wire

FILE: src/ssd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_back - digit emitter
// Takes queued refresh jobs, extracts one decimal digit per cycle unless the
// output stalls, from the most significant position down, blanks leading
// zeros in counter mode and presents each lit digit in an output register.
// ----------------------------------------------------------------------------
module ssd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ssd_pkg::job_t    q_job,
  input  wire ssd_pkg::q_stat_t q_stat,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [1:0]            out_digit_index,
  output logic [6:0]            out_segments,
  output logic                  out_last_digit
);
  import ssd_pkg::*;

  logic             busy_r, busy_nxt;
  logic [VAL_W-1:0] rem_r, rem_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             lit_r, lit_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_idx_r;
  logic [SEG_W-1:0] out_seg_r;
  logic             out_last_r;

  logic             advance;
  logic             at_units;
  logic             emit;
  logic             lit_now;
  logic [POW_W-1:0] pw;
  logic [POW_W-1:0] rem_ext;
  logic [POW_W-1:0] sub;
  logic [DIG_W-1:0] digit;

  // Step when working and the output register is free or being taken
  assign advance  = busy_r && (!out_valid_r || !out_stall);
  assign at_units = (pos_r == '0);
  assign q_pop    = !q_stat.empty && (!busy_r || (advance && at_units));

  // Extract the digit at the current position by threshold compare
  always_comb begin
    pw      = POW10[pos_r];
    rem_ext = POW_W'(rem_r);
    digit   = '0;
    sub     = '0;
    for (int c = 1; c < 10; c++) begin
      if (rem_ext >= POW_W'(POW_W'(c) * pw)) begin
        digit = DIG_W'(c);
        sub   = POW_W'(POW_W'(c) * pw);
      end
    end
  end

  // Decide whether the digit is shown
  assign lit_now = lit_r || (digit != '0) || at_units;
  assign emit    = advance && ({1'b0, pos_r} < DIGITS_P) && lit_now;

  // Sequence through positions and load the next job
  always_comb begin
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    pos_nxt  = pos_r;
    lit_nxt  = lit_r;
    if (advance) begin
      rem_nxt = VAL_W'(rem_ext - sub);
      pos_nxt = pos_r - POS_W'(1);
      if ({1'b0, pos_r} < DIGITS_P) begin
        lit_nxt = lit_now;
      end
      if (at_units) begin
        busy_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
      rem_nxt  = q_job.value;
      pos_nxt  = TOP_POS;
      lit_nxt  = !q_job.show_counter;
    end
  end

  // Hold a stalled result, drop a taken one
  assign out_valid_nxt = advance ? emit : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    pos_r <= pos_nxt;
    lit_r <= lit_nxt;
    if (emit) begin
      out_idx_r  <= pos_r[IDX_W-1:0];
      out_seg_r  <= seg_of(digit);
      out_last_r <= at_units;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_digit_index = out_idx_r;
  assign out_segments    = out_seg_r;
  assign out_last_digit  = out_last_r;

  a_last_is_units: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_idx_r == '0)
    else $error("last digit mark away from the units position");

  a_units_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    advance && at_units && !q_pop |=> !busy_r)
    else $error("job still active after its units digit");

endmodule
`default_nettype wire

FILE: src/four_digit_seven_segment_counter_display.sv
`default_nettype none
// ----------------------------------------------------------------------------
// four_digit_seven_segment_counter_display - counter and sample display driver
// Decimal counter, converter sample and display mode with a seven-segment
// digit emitter behind a short refresh queue.
// ----------------------------------------------------------------------------
// Tick, sample and button items are taken one per cycle while input is not
// stalled and act at once. A refresh item is queued and then steps the digit
// emitter through every position of the four-digit display, whether or not
// a position is blanked; each lit digit leaves through an output register,
// thousands first, the units digit marked last. The emitter's one-digit-per-
// cycle extraction, held while the output stalls, sets the refresh rate;
// input is stalled only while the two-entry refresh queue is full.
// ----------------------------------------------------------------------------
module four_digit_seven_segment_counter_display (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_command,
  input  wire logic [9:0] in_adc_sample,
  input  wire logic       in_button_level,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_digit_index,
  output logic [6:0]      out_segments,
  output logic            out_last_digit
);
  import ssd_pkg::*;

  logic    q_push;
  logic    q_pop;
  job_t    push_job;
  job_t    pop_job;
  q_stat_t q_stat;

  // Decode commands and keep the display state
  ssd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_adc_sample   (in_adc_sample),
    .in_button_level (in_button_level),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_job           (push_job)
  );

  // Buffer refresh jobs
  ssd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  // Emit digit patterns
  ssd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_job           (pop_job),
    .q_stat          (q_stat),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digit_index (out_digit_index),
    .out_segments    (out_segments),
    .out_last_digit  (out_last_digit)
  );

endmodule
`default_nettype wire
